// File: hdl/flpc_pkg.sv
package flpc_pkg;

  typedef enum logic [1:0] {
    ACT_ACCUM = 2'd0,
    ACT_LABEL = 2'd1,
    ACT_EVAL  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  localparam int unsigned FlowW  = 16;
  localparam int unsigned AccW   = 20;
  localparam int unsigned DimW   = 9;
  localparam int unsigned PixW   = 8;
  localparam int unsigned ErrW   = 16;
  localparam int unsigned LabInW = 8;
  localparam int unsigned LabOutW = 9;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_SRC,
    ST_WR_SRC,
    ST_LAND,
    ST_RD_LAND,
    ST_SQUARE,
    ST_SUM,
    ST_SQRT,
    ST_ROUND,
    ST_OUT
  } state_e;

  // saturate a wide signed sum to the accumulator range
  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [AccW+1:0] v);
    logic signed [AccW+1:0] hi;
    logic signed [AccW+1:0] lo;
    hi = (AccW+2)'(2 ** (AccW - 1) - 1);
    lo = -(AccW+2)'(2 ** (AccW - 1));
    if (v > hi) begin
      return hi[AccW-1:0];
    end else if (v < lo) begin
      return lo[AccW-1:0];
    end
    return v[AccW-1:0];
  endfunction

endpackage

// File: hdl/flpc_if.sv
interface flpc_in_if;
  import flpc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic                     first_frame;
  logic [PixW-1:0]          pixel_x;
  logic [PixW-1:0]          pixel_y;
  logic signed [FlowW-1:0]  fwd_u;
  logic signed [FlowW-1:0]  fwd_v;
  logic signed [FlowW-1:0]  bwd_u;
  logic signed [FlowW-1:0]  bwd_v;
  logic [LabInW-1:0]        label_in;
  modport source (output valid, action, first_frame, pixel_x, pixel_y, fwd_u, fwd_v,
                  bwd_u, bwd_v, label_in, input ready);
  modport sink (input valid, action, first_frame, pixel_x, pixel_y, fwd_u, fwd_v,
                bwd_u, bwd_v, label_in, output ready);
endinterface

interface flpc_out_if;
  import flpc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      inside_res;
  logic [ErrW-1:0]           err_dist;
  logic signed [LabOutW-1:0] warped_label;
  modport source (output valid, inside_res, err_dist, warped_label, input ready);
  modport sink (input valid, inside_res, err_dist, warped_label, output ready);
endinterface

interface flpc_cfg_if;
  import flpc_pkg::*;
  logic            valid;
  logic            ready;
  logic [0:0]      index;
  logic [DimW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/flpc_ram.sv
module flpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: hdl/flpc_sqrt.sv
module flpc_sqrt #(
  parameter int unsigned InW = 44
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [InW-1:0]     rad_i,
  output logic               done_o,
  output logic [InW/2-1:0]   root_o,
  output logic [InW/2:0]     rem_o
);
  localparam int unsigned RootW = InW / 2;
  localparam int unsigned CntW = $clog2(RootW + 1);

  logic [InW-1:0]   rad_q, rad_d;
  logic [RootW-1:0] root_q, root_d;
  logic [RootW+1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [RootW+1:0] trial;

  // restoring square root, one result bit per cycle
  always_comb begin
    rad_d  = rad_q;
    root_d = root_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[RootW-1:0], rad_q[InW-1 -: 2]} - {root_q, 2'b01};
    if (start_i) begin
      rad_d  = rad_i;
      root_d = '0;
      rem_d  = '0;
      cnt_d  = CntW'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[InW-3:0], 2'b00};
      if (!trial[RootW+1]) begin
        rem_d  = trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[RootW-1:0], rad_q[InW-1 -: 2]};
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign root_o = root_d;
  assign rem_o  = rem_d[RootW:0];
endmodule

// File: hdl/flow_label_propagation_consistency_core.sv
// One item at a time. Accumulate and label writes go through accept, read and
// write back to the per-pixel RAM; action 3 and writes outside the frame end
// after the read. Evaluate goes through accept, read of the source pixel,
// landing computation, dependent read at the landing pixel, two squares, their
// sum, a 22-step bit-serial square root, rounding and the output state; an
// evaluate outside the frame, or landing outside it, goes to the output state
// straight after its read. The result sits in an output register until taken;
// one evaluate result is outstanding at most, and no new item is accepted while
// the receiver holds off. Flow state lives in one 80-bit wide RAM, labels in a
// second RAM, both 2**AW deep and undefined until written.
module flow_label_propagation_consistency_core #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned FRAC_BITS  = 5,
  parameter int unsigned LABEL_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  flpc_in_if.sink          in_if,
  flpc_out_if.source       out_if,
  flpc_cfg_if.sink         cfg_if
);
  import flpc_pkg::*;

  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned Depth = 1 << AW;
  localparam int unsigned FlowRamW = 4 * AccW;
  localparam int unsigned CW    = 22;  // signed landing coordinate
  localparam int unsigned DW    = 24;  // signed error component
  localparam int unsigned SqW   = 44;
  localparam int unsigned LbW   = (LABEL_BITS < LabInW) ? LABEL_BITS : LabInW;

  // configuration
  logic [DimW-1:0] width_q, height_q;
  logic [12:0] w_eff, h_eff;
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(256);
      height_q <= DimW'(256);
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_WIDTH:  width_q  <= cfg_if.data;
        REG_HEIGHT: height_q <= cfg_if.data;
        default: ;
      endcase
    end
  end
  always_comb begin
    w_eff = (width_q == '0) ? 13'd1 : 13'(width_q);
    if (w_eff > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
    h_eff = (height_q == '0) ? 13'd1 : 13'(height_q);
    if (h_eff > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
  end

  state_e state_q, state_d;

  // captured item
  logic [1:0] act_q;
  logic first_q;
  logic [PixW-1:0] x_q, y_q;
  logic signed [FlowW-1:0] fu_q, fv_q, bu_q, bv_q;
  logic [LabInW-1:0] lab_q;
  logic signed [CW-1:0] la_q, lb_q, la_d, lb_d;
  logic signed [DW-1:0] s_q, t_q;
  logic signed [DW-1:0] dx, dy, s_d, t_d;
  logic signed [2*DW-1:0] ss_full, tt_full;
  logic [SqW-1:0] ss_q, tt_q;
  logic [SqW-1:0] n_sum;
  logic res_in_q, res_in_d;
  logic [ErrW-1:0] res_err_q, res_err_d;
  logic signed [LabOutW-1:0] res_lab_q, res_lab_d;
  logic out_valid_q;

  // memories
  logic flow_we, lab_we;
  logic [AW-1:0] flow_raddr, waddr;
  logic [FlowRamW-1:0] flow_wdata, flow_rdata;
  logic [LbW-1:0] lab_rdata;
  logic [LbW-1:0] lab_land_q;

  flpc_ram #(.Width(FlowRamW), .Depth(Depth)) u_flow_ram (
    .clk_i, .we_i(flow_we), .waddr_i(waddr), .wdata_i(flow_wdata),
    .raddr_i(flow_raddr), .rdata_o(flow_rdata)
  );
  flpc_ram #(.Width(LbW), .Depth(Depth)) u_label_ram (
    .clk_i, .we_i(lab_we), .waddr_i(waddr), .wdata_i(lab_q[LbW-1:0]),
    .raddr_i(flow_raddr), .rdata_o(lab_rdata)
  );

  logic src_in;
  assign src_in = (13'(in_if.pixel_x) < w_eff) && (13'(in_if.pixel_y) < h_eff);
  logic src_in_q;

  // unpack the stored accumulators
  logic signed [AccW-1:0] a_fu, a_fv, a_bu, a_bv;
  assign {a_fu, a_fv, a_bu, a_bv} = flow_rdata;

  // landing computation: floor((coord<<F + acc + half) >> F)
  localparam int unsigned Half = (FRAC_BITS > 0) ? (1 << FRAC_BITS) / 2 : 0;
  logic signed [CW+FRAC_BITS-1:0] pa, pb;
  always_comb begin
    pa = ($signed({1'b0, (CW+FRAC_BITS-1)'(x_q)}) <<< FRAC_BITS)
         + (CW+FRAC_BITS)'(a_fu) + (CW+FRAC_BITS)'(Half);
    pb = ($signed({1'b0, (CW+FRAC_BITS-1)'(y_q)}) <<< FRAC_BITS)
         + (CW+FRAC_BITS)'(a_fv) + (CW+FRAC_BITS)'(Half);
    la_d = CW'(pa >>> FRAC_BITS);
    lb_d = CW'(pb >>> FRAC_BITS);
  end
  logic land_in;
  assign land_in = !la_q[CW-1] && !lb_q[CW-1] && (la_q < CW'(w_eff)) && (lb_q < CW'(h_eff));

  // error components and their squares, all signed
  assign dx      = DW'(la_q) - DW'($signed({1'b0, x_q}));
  assign dy      = DW'(lb_q) - DW'($signed({1'b0, y_q}));
  assign s_d     = (dx <<< FRAC_BITS) + DW'(a_bu);
  assign t_d     = (dy <<< FRAC_BITS) + DW'(a_bv);
  assign ss_full = s_q * s_q;
  assign tt_full = t_q * t_q;
  assign n_sum   = ss_q + tt_q;

  // sqrt unit
  logic sq_start, sq_done;
  logic [SqW/2-1:0] root;
  logic [SqW/2:0] rem;
  flpc_sqrt #(.InW(SqW)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(n_sum),
    .done_o(sq_done), .root_o(root), .rem_o(rem)
  );
  logic [SqW/2-1:0] root_q;
  logic [SqW/2:0] rem_q;
  logic [SqW/2:0] rnd;
  assign rnd = 23'(root_q) + ((rem_q > 23'(root_q)) ? 23'd1 : 23'd0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_if.valid) state_d = ST_RD_SRC;
      ST_RD_SRC: begin
        if (!src_in_q || act_q == ACT_NONE) state_d = ST_IDLE;
        else if (act_q == ACT_EVAL) state_d = ST_LAND;
        else state_d = ST_WR_SRC;
      end
      ST_WR_SRC:  state_d = ST_IDLE;
      ST_LAND:    state_d = ST_RD_LAND;
      ST_RD_LAND: state_d = land_in ? ST_SQUARE : ST_OUT;
      ST_SQUARE:  state_d = ST_SUM;
      ST_SUM:     state_d = ST_SQRT;
      ST_SQRT:    if (sq_done) state_d = ST_ROUND;
      ST_ROUND:   state_d = ST_OUT;
      ST_OUT:     if (!out_valid_q) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
    if (state_q == ST_RD_SRC && !src_in_q && act_q == ACT_EVAL) state_d = ST_OUT;
  end

  // outputs and datapath control
  always_comb begin
    flow_we    = 1'b0;
    lab_we     = 1'b0;
    flow_raddr = {y_q[YW-1:0], x_q[XW-1:0]};
    waddr      = {y_q[YW-1:0], x_q[XW-1:0]};
    flow_wdata = '0;
    sq_start   = (state_q == ST_SUM);
    res_in_d   = res_in_q;
    res_err_d  = res_err_q;
    res_lab_d  = res_lab_q;
    unique case (state_q)
      ST_IDLE:    flow_raddr = {in_if.pixel_y[YW-1:0], in_if.pixel_x[XW-1:0]};
      ST_RD_SRC: begin
        if (!src_in_q || act_q == ACT_EVAL) begin
          res_in_d  = 1'b0;
          res_err_d = '0;
          res_lab_d = '1;
        end
      end
      ST_WR_SRC: begin
        if (act_q == ACT_ACCUM) begin
          flow_we = 1'b1;
          if (first_q) begin
            flow_wdata = {AccW'(fu_q), AccW'(fv_q), AccW'(bu_q), AccW'(bv_q)};
          end else begin
            flow_wdata = {sat_acc((AccW+2)'(a_fu) + (AccW+2)'(fu_q)),
                          sat_acc((AccW+2)'(a_fv) + (AccW+2)'(fv_q)),
                          sat_acc((AccW+2)'(a_bu) + (AccW+2)'(bu_q)),
                          sat_acc((AccW+2)'(a_bv) + (AccW+2)'(bv_q))};
          end
        end else begin
          lab_we = 1'b1;
        end
      end
      ST_LAND:    flow_raddr = {lb_q[YW-1:0], la_q[XW-1:0]};
      ST_ROUND: begin
        res_in_d  = 1'b1;
        res_err_d = (rnd > 23'hFFFF) ? 16'hFFFF : rnd[ErrW-1:0];
        res_lab_d = LabOutW'({1'b0, lab_land_q});
      end
      default: ;
    endcase
  end

  // capture the accepted transaction and the intermediate results
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      act_q    <= in_if.action;
      first_q  <= in_if.first_frame;
      x_q      <= in_if.pixel_x;
      y_q      <= in_if.pixel_y;
      fu_q     <= in_if.fwd_u;
      fv_q     <= in_if.fwd_v;
      bu_q     <= in_if.bwd_u;
      bv_q     <= in_if.bwd_v;
      lab_q    <= in_if.label_in;
      src_in_q <= src_in;
    end
    if (state_q == ST_RD_SRC) begin
      la_q <= la_d;
      lb_q <= lb_d;
    end
    if (state_q == ST_RD_LAND) begin
      s_q        <= s_d;
      t_q        <= t_d;
      lab_land_q <= lab_rdata;
    end
    if (state_q == ST_SQUARE) begin
      ss_q <= ss_full[SqW-1:0];
      tt_q <= tt_full[SqW-1:0];
    end
    if (sq_done) begin
      root_q <= root;
      rem_q  <= rem;
    end
    res_in_q  <= res_in_d;
    res_err_q <= res_err_d;
    res_lab_q <= res_lab_d;
  end

  // state register and result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_d == ST_OUT && state_q != ST_OUT) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
    end
  end

  assign in_if.ready         = (state_q == ST_IDLE);
  assign out_if.valid        = out_valid_q;
  assign out_if.inside_res   = res_in_q;
  assign out_if.err_dist     = res_err_q;
  assign out_if.warped_label = res_lab_q;

  // a result is only offered while an evaluate is finishing
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == ST_OUT) else $error("result outside output state");
  // outside results carry the fixed answer
  a_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_in_q) |-> (res_err_q == '0 && res_lab_q == '1))
    else $error("outside result not canonical");
  // only evaluates produce results
  a_eval_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> act_q == ACT_EVAL) else $error("result without evaluate");
endmodule

// File: tb/flow_label_propagation_consistency_core_tb.sv
`timescale 1ns / 100ps

module flow_label_propagation_consistency_core_tb;
  import flpc_pkg::*;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned RandomItems = 840;
  localparam int unsigned SettleCyc   = 60;
  localparam int unsigned MaxShown    = 10;

  typedef struct {
    action_e            act;
    bit                 first;
    bit [7:0]           x;
    bit [7:0]           y;
    bit signed [15:0]   fu;
    bit signed [15:0]   fv;
    bit signed [15:0]   bu;
    bit signed [15:0]   bv;
    bit [7:0]           lab;
  } pix_item_t;

  typedef struct {
    bit               in_frame;
    bit [15:0]        err;
    bit signed [8:0]  lab;
  } warp_result_t;

  // per-pixel flow and label shadow, predicts evaluate answers
  class consistency_scoreboard;
    bit signed [19:0] acc_fu[65536];
    bit signed [19:0] acc_fv[65536];
    bit signed [19:0] acc_bu[65536];
    bit signed [19:0] acc_bv[65536];
    bit [7:0]         lab_mem[65536];
    bit               flow_ok[65536];
    bit               lab_ok[65536];
    int               flow_list[$];
    int unsigned      width_reg;
    int unsigned      height_reg;
    warp_result_t     awaited[$];
    int               failures;

    function new();
      width_reg  = 256;
      height_reg = 256;
      failures   = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v);
      if (v < 1) return 1;
      if (v > 256) return 256;
      return v;
    endfunction

    function void set_reg(bit idx, bit [8:0] data);
      if (idx == REG_WIDTH) width_reg = 32'(data);
      else height_reg = 32'(data);
    endfunction

    function bit signed [19:0] sat20(longint v);
      if (v > 524287) return 20'sd524287;
      if (v < -524288) return -20'sd524288;
      return v[19:0];
    endfunction

    // round to nearest, ties upward
    function longint land_coord(int unsigned c, bit signed [19:0] f);
      longint v;
      v = longint'(c) * 32 + longint'(f) + 16;
      return v >>> 5;
    endfunction

    function longint unsigned root_round(longint unsigned n);
      longint unsigned r;
      longint unsigned cand;
      r = 0;
      for (int k = 22; k >= 0; k--) begin
        cand = r | (longint'(1) << k);
        if (cand * cand <= n) r = cand;
      end
      if (n - r * r > r) r++;
      return r;
    endfunction

    function bit src_inside(pix_item_t it);
      return (it.x < clamp_dim(width_reg)) && (it.y < clamp_dim(height_reg));
    endfunction

    // true when an evaluate reads only entries that were written
    function bit eval_safe(pix_item_t it);
      int idx;
      longint a;
      longint b;
      int li;
      idx = int'({it.y, it.x});
      if (!flow_ok[idx]) return 0;
      if (!src_inside(it)) return 1;
      a = land_coord(it.x, acc_fu[idx]);
      b = land_coord(it.y, acc_fv[idx]);
      if (a < 0 || a >= clamp_dim(width_reg) || b < 0 || b >= clamp_dim(height_reg)) return 1;
      li = int'(b) * 256 + int'(a);
      return flow_ok[li] && lab_ok[li];
    endfunction

    function warp_result_t predict_eval(pix_item_t it);
      warp_result_t r;
      int idx;
      int li;
      longint a;
      longint b;
      longint s;
      longint t;
      longint unsigned d;
      r.in_frame = 0;
      r.err      = 0;
      r.lab      = -9'sd1;
      idx = int'({it.y, it.x});
      if (!src_inside(it)) return r;
      a = land_coord(it.x, acc_fu[idx]);
      b = land_coord(it.y, acc_fv[idx]);
      if (a < 0 || a >= clamp_dim(width_reg) || b < 0 || b >= clamp_dim(height_reg)) return r;
      li = int'(b) * 256 + int'(a);
      s = (a - longint'(it.x)) * 32 + longint'(acc_bu[li]);
      t = (b - longint'(it.y)) * 32 + longint'(acc_bv[li]);
      d = root_round(longint'(s * s) + longint'(t * t));
      if (d > 65535) d = 65535;
      r.in_frame = 1;
      r.err      = d[15:0];
      r.lab      = {1'b0, lab_mem[li]};
      return r;
    endfunction

    function void note_input(pix_item_t it);
      int idx;
      idx = int'({it.y, it.x});
      case (it.act)
        ACT_ACCUM: begin
          if (src_inside(it)) begin
            if (it.first) begin
              acc_fu[idx] = sat20(it.fu);
              acc_fv[idx] = sat20(it.fv);
              acc_bu[idx] = sat20(it.bu);
              acc_bv[idx] = sat20(it.bv);
              if (!flow_ok[idx]) flow_list.insert(flow_list.size(), idx);
              flow_ok[idx] = 1;
            end else begin
              acc_fu[idx] = sat20(longint'(acc_fu[idx]) + it.fu);
              acc_fv[idx] = sat20(longint'(acc_fv[idx]) + it.fv);
              acc_bu[idx] = sat20(longint'(acc_bu[idx]) + it.bu);
              acc_bv[idx] = sat20(longint'(acc_bv[idx]) + it.bv);
            end
          end
        end
        ACT_LABEL: begin
          if (src_inside(it)) begin
            lab_mem[idx] = it.lab;
            lab_ok[idx]  = 1;
          end
        end
        ACT_EVAL: awaited.insert(awaited.size(), predict_eval(it));
        default: ;
      endcase
    endfunction

    function void check_result(warp_result_t got);
      warp_result_t exp_r;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= MaxShown)
          $display("unexpected result transaction: inside %0d err %0d label %0d",
                   got.in_frame, got.err, got.lab);
        return;
      end
      exp_r = awaited.pop_front();
      if (got.in_frame !== exp_r.in_frame || got.err !== exp_r.err ||
          got.lab !== exp_r.lab) begin
        failures++;
        if (failures <= MaxShown)
          $display("result mismatch: exp inside %0d err %0d label %0d, got %0d %0d %0d",
                   exp_r.in_frame, exp_r.err, exp_r.lab, got.in_frame, got.err, got.lab);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady;
  int   results_taken;
  int   cycles;

  flpc_in_if  in_if();
  flpc_out_if out_if();
  flpc_cfg_if cfg_if();

  consistency_scoreboard sb = new();

  flow_label_propagation_consistency_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("flow_label_propagation_consistency_core_tb: FAIL");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    warp_result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.in_frame = out_if.inside_res;
      got.err      = out_if.err_dist;
      got.lab      = out_if.warped_label;
      sb.check_result(got);
      results_taken++;
    end
  end

  // receiver side, with one long hold-off
  initial begin
    bit held;
    held = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_taken >= 150) begin
        out_if.ready = 1'b0;
        repeat (300) @(negedge clk_i);
        held = 1;
      end
      out_if.ready = steady || ($urandom_range(0, 99) >= 15);
    end
  end

  function automatic pix_item_t mk(action_e act, bit first, int x, int y, int fu, int fv,
                                   int bu, int bv, int lab);
    pix_item_t it;
    it.act = act;       it.first = first;
    it.x = 8'(x);       it.y = 8'(y);
    it.fu = 16'(fu);    it.fv = 16'(fv);
    it.bu = 16'(bu);    it.bv = 16'(bv);
    it.lab = 8'(lab);
    return it;
  endfunction

  // coordinate in the working corners of the frame
  function automatic int corner_coord();
    int v;
    v = $urandom_range(0, 13);
    return (v < 10) ? v : v + 242;
  endfunction

  function automatic bit signed [15:0] rand_flow();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 16'(int'($urandom_range(0, 192)) - 96);
    if (sel < 85) return 16'($urandom);
    return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
  endfunction

  function automatic pix_item_t random_item();
    pix_item_t it;
    int sel;
    int idx;
    if ($urandom_range(0, 99) < 80) begin
      it.x = 8'(corner_coord());
      it.y = 8'(corner_coord());
    end else begin
      it.x = 8'($urandom);
      it.y = 8'($urandom);
    end
    it.fu = rand_flow();
    it.fv = rand_flow();
    it.bu = rand_flow();
    it.bv = rand_flow();
    it.lab = 8'($urandom);
    it.first = 1;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      it.act = ACT_EVAL;
      for (int k = 0; k < 20; k++) begin
        idx = sb.flow_list[$urandom_range(0, sb.flow_list.size() - 1)];
        it.x = idx[7:0];
        it.y = idx[15:8];
        if (sb.eval_safe(it)) return it;
      end
      it.act = ACT_LABEL;
    end else if (sel < 80) begin
      it.act = ACT_ACCUM;
      if (sel >= 65 && sb.flow_ok[{it.y, it.x}]) it.first = 0;
    end else if (sel < 95) begin
      it.act = ACT_LABEL;
    end else begin
      it.act = ACT_NONE;
      it.first = 1'($urandom);
    end
    return it;
  endfunction

  task automatic send_item(pix_item_t it);
    if (!steady && $urandom_range(0, 99) < 15) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_if.action      = it.act;
    in_if.first_frame = it.first;
    in_if.pixel_x     = it.x;
    in_if.pixel_y     = it.y;
    in_if.fwd_u       = it.fu;
    in_if.fwd_v       = it.fv;
    in_if.bwd_u       = it.bu;
    in_if.bwd_v       = it.bv;
    in_if.label_in    = it.lab;
    in_if.valid       = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(it);
    @(negedge clk_i);
  endtask

  // drain results, let the block go idle, then write one register
  task automatic write_reg(bit idx, bit [8:0] data);
    in_if.valid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
    cfg_if.index = idx;
    cfg_if.data  = data;
    cfg_if.valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  initial begin
    int widths[7];
    int heights[7];
    rst_ni = 1'b0;
    steady = 0;
    results_taken = 0;
    cycles = 0;
    in_if.valid = 1'b0;
    in_if.action = ACT_NONE;
    in_if.first_frame = 1'b0;
    in_if.pixel_x = '0;
    in_if.pixel_y = '0;
    in_if.fwd_u = '0;
    in_if.fwd_v = '0;
    in_if.bwd_u = '0;
    in_if.bwd_v = '0;
    in_if.label_in = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_WIDTH;
    cfg_if.data = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_reg(REG_WIDTH, 9'd256);
    write_reg(REG_HEIGHT, 9'd256);

    // fill the frame corners with small flows and labels
    for (int yy = 0; yy < 14; yy++) begin
      for (int xx = 0; xx < 14; xx++) begin
        int px;
        int py;
        px = (xx < 10) ? xx : xx + 242;
        py = (yy < 10) ? yy : yy + 242;
        send_item(mk(ACT_ACCUM, 1, px, py, $urandom_range(0, 96) - 48,
                     $urandom_range(0, 96) - 48, $urandom_range(0, 96) - 48,
                     $urandom_range(0, 96) - 48, 0));
        send_item(mk(ACT_LABEL, 0, px, py, 0, 0, 0, 0, $urandom));
      end
    end

    // directed: label extremes, one pixel step, ties, flow extremes, repeated accumulation
    send_item(mk(ACT_LABEL, 0, 1, 0, 0, 0, 0, 0, 255));
    send_item(mk(ACT_LABEL, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(ACT_ACCUM, 1, 0, 0, 32, 0, -32, 0, 0));
    send_item(mk(ACT_EVAL, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(ACT_ACCUM, 1, 3, 3, -16, 16, 5, -7, 0));
    send_item(mk(ACT_EVAL, 0, 3, 3, 0, 0, 0, 0, 0));
    send_item(mk(ACT_ACCUM, 1, 255, 255, -32, -32, 0, 0, 0));
    send_item(mk(ACT_EVAL, 0, 255, 255, 0, 0, 0, 0, 0));
    send_item(mk(ACT_ACCUM, 1, 1, 1, 32767, -32768, 32767, -32768, 0));
    send_item(mk(ACT_EVAL, 0, 1, 1, 0, 0, 0, 0, 0));
    for (int k = 0; k < 12; k++)
      send_item(mk(ACT_ACCUM, 0, 2, 2, 32767, -32768, 32767, -32768, 0));
    send_item(mk(ACT_EVAL, 0, 2, 2, 0, 0, 0, 0, 0));
    send_item(mk(ACT_NONE, 1, 255, 255, -1, -1, -1, -1, 255));

    // random phases over several frame sizes, extremes included
    widths  = '{256, 1, 0, 511, 17, 0, 256};
    heights = '{256, 1, 511, 0, 5, 0, 256};
    widths[5]  = $urandom_range(1, 256);
    heights[5] = $urandom_range(1, 256);
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_WIDTH, 9'(widths[ph]));
      write_reg(REG_HEIGHT, 9'(heights[ph]));
      steady = (ph == 4);
      for (int n = 0; n < RandomItems / 7; n++) send_item(random_item());
    end
    in_if.valid = 1'b0;

    while (sb.awaited.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
    if (sb.failures == 0 && sb.awaited.size() == 0) begin
      $display("flow_label_propagation_consistency_core_tb: PASS");
    end else begin
      $display("flow_label_propagation_consistency_core_tb: FAIL");
    end
    $finish;
  end

endmodule
